>>> sv/eif_pkg.sv
// Shared types, widths, fit constants and table builders for the exponential integral fit.
// No dependencies; used by eif_exp_lane and exponential_integral_fit.
package eif_pkg;

  localparam int ORD_W = 2;
  localparam int X_W = 24;
  localparam int K_W = 29;
  localparam int A_W = 31;
  localparam int T_W = X_W + K_W;
  localparam int FRAC_LSB = 8;
  localparam int FRAC_W = 32;
  localparam int IP_LSB = FRAC_LSB + FRAC_W;
  localparam int IP_W = T_W - IP_LSB;
  localparam int M_W = 32;
  localparam int P_W = A_W + M_W;
  localparam int OUT_W = 32;
  localparam int MAX_SHIFT = 32;
  localparam int EXP_TABLE_BITS_DEF = 8;

  localparam logic [ORD_W-1:0] ORD_NONE = 2'd0;
  localparam logic [ORD_W-1:0] ORD_E1 = 2'd1;
  localparam logic [ORD_W-1:0] ORD_E2 = 2'd2;
  localparam logic [ORD_W-1:0] ORD_E3 = 2'd3;

  localparam logic [63:0] LOG2E_Q32 = 64'h1_7154_7652;

  localparam logic [63:0] K_E1_0 = (64'd187000 * LOG2E_Q32 + 64'd1280000) / 64'd2560000;
  localparam logic [63:0] K_E1_1 = (64'd21100 * LOG2E_Q32 + 64'd1280000) / 64'd2560000;
  localparam logic [63:0] K_E2_0 = (64'd86590 * LOG2E_Q32 + 64'd1280000) / 64'd2560000;
  localparam logic [63:0] K_E2_1 = (64'd16240 * LOG2E_Q32 + 64'd1280000) / 64'd2560000;
  localparam logic [63:0] K_E3_0 = (64'd40800 * LOG2E_Q32 + 64'd1280000) / 64'd2560000;
  localparam logic [63:0] K_E3_1 = (64'd13300 * LOG2E_Q32 + 64'd1280000) / 64'd2560000;

  localparam logic [63:0] A_E1_0 = ((64'd25910 << 29) + 64'd5000) / 64'd10000;
  localparam logic [63:0] A_E1_1 = ((64'd17080 << 29) + 64'd5000) / 64'd10000;
  localparam logic [63:0] A_E2_0 = ((64'd2653 << 29) + 64'd5000) / 64'd10000;
  localparam logic [63:0] A_E2_1 = ((64'd7347 << 29) + 64'd5000) / 64'd10000;
  localparam logic [63:0] A_E3_0 = ((64'd929 << 29) + 64'd5000) / 64'd10000;
  localparam logic [63:0] A_E3_1 = ((64'd4071 << 29) + 64'd5000) / 64'd10000;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } eif_ld_t;

  function automatic logic [K_W-1:0] coef_k(logic [ORD_W-1:0] ord, logic term);
    logic [63:0] k;
    k = '0;
    unique case (ord)
      ORD_E2:  k = term ? K_E2_1 : K_E2_0;
      ORD_E3:  k = term ? K_E3_1 : K_E3_0;
      default: k = term ? K_E1_1 : K_E1_0;
    endcase
    return k[K_W-1:0];
  endfunction

  function automatic logic [A_W-1:0] coef_a(logic [ORD_W-1:0] ord, logic term);
    logic [63:0] a;
    a = '0;
    unique case (ord)
      ORD_E2:  a = term ? A_E2_1 : A_E2_0;
      ORD_E3:  a = term ? A_E3_1 : A_E3_0;
      default: a = term ? A_E1_1 : A_E1_0;
    endcase
    return a[A_W-1:0];
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    int n;
    v = v_in;
    res = '0;
    bt = 64'h4000_0000_0000_0000;
    for (n = 0; n < 32; n++) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] root_factor(int k, int bits);
    logic [63:0] v;
    int n;
    v = 64'd1 << 30;
    for (n = 0; n < bits - k; n++) begin
      v = isqrt64(v << 31);
    end
    return v;
  endfunction

  function automatic logic [31:0] table_entry(int j, int bits);
    logic [63:0] p;
    int k;
    p = 64'd1 << 31;
    if (j >= (1 << bits)) begin
      p = 64'd1 << 30;
    end else begin
      for (k = 0; k < bits; k++) begin
        if (((j >> k) & 1) != 0) begin
          p = (p * root_factor(k, bits) + (64'd1 << 30)) >> 31;
        end
      end
    end
    return p[31:0];
  endfunction

endpackage

>>> sv/eif_exp_lane.sv
// One scaled power-of-two term a*2^(-k*x): multiply, table read, interpolate, scale, shift.
// Depends on eif_pkg; stage loads come from exponential_integral_fit.
module eif_exp_lane #(
  parameter int EXP_TABLE_BITS = eif_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                      clk,
  input  eif_pkg::eif_ld_t          ld,
  input  logic [eif_pkg::X_W-1:0]   x_i,
  input  logic [eif_pkg::K_W-1:0]   k_i,
  input  logic [eif_pkg::A_W-1:0]   a_i,
  output logic [eif_pkg::OUT_W-1:0] term_o
);

  localparam int SUB_W = eif_pkg::FRAC_W - EXP_TABLE_BITS;
  localparam int TAB_D = (1 << EXP_TABLE_BITS) + 1;
  localparam int IDX_W = EXP_TABLE_BITS + 1;
  localparam int IP_MSB = eif_pkg::FRAC_LSB + eif_pkg::FRAC_W - 1;
  localparam int D_W = eif_pkg::M_W + SUB_W;

  logic [31:0] rom [TAB_D];

  for (genvar g = 0; g < TAB_D; g++) begin : g_rom
    localparam logic [31:0] ENTRY = eif_pkg::table_entry(g, EXP_TABLE_BITS);
    assign rom[g] = ENTRY;
  end

  logic [eif_pkg::T_W-1:0]   t_r;
  logic [eif_pkg::T_W-1:0]   t_nxt;
  logic [IDX_W-1:0]          j_lo;
  logic [IDX_W-1:0]          j_hi;
  logic [31:0]               lo3_r;
  logic [31:0]               hi3_r;
  logic [SUB_W-1:0]          r3_r;
  logic [eif_pkg::IP_W-1:0]  ip3_r;
  logic [31:0]               diff;
  logic [D_W-1:0]            prod4;
  logic [31:0]               interp4_r;
  logic [31:0]               lo4_r;
  logic [eif_pkg::IP_W-1:0]  ip4_r;
  logic [eif_pkg::M_W-1:0]   m5_r;
  logic [eif_pkg::IP_W-1:0]  ip5_r;
  logic [eif_pkg::P_W-1:0]   p6_r;
  logic [eif_pkg::P_W-1:0]   p6_nxt;
  logic [eif_pkg::IP_W-1:0]  ip6_r;
  logic [31:0]               scaled;

  assign t_nxt = eif_pkg::T_W'(x_i) * eif_pkg::T_W'(k_i);
  assign j_lo = {1'b0, t_r[IP_MSB -: EXP_TABLE_BITS]};
  assign j_hi = j_lo + IDX_W'(1);
  assign diff = lo3_r - hi3_r;
  assign prod4 = D_W'(diff) * D_W'(r3_r);
  assign p6_nxt = eif_pkg::P_W'(a_i) * eif_pkg::P_W'(m5_r);
  assign scaled = p6_r[eif_pkg::P_W-1 -: 32];

  always_ff @(posedge clk) begin
    if (ld.s2) begin
      t_r <= t_nxt;
    end
    if (ld.s3) begin
      lo3_r <= rom[j_lo];
      hi3_r <= rom[j_hi];
      r3_r <= t_r[eif_pkg::FRAC_LSB +: SUB_W];
      ip3_r <= t_r[eif_pkg::T_W-1:eif_pkg::IP_LSB];
    end
    if (ld.s4) begin
      interp4_r <= prod4[SUB_W +: 32];
      lo4_r <= lo3_r;
      ip4_r <= ip3_r;
    end
    if (ld.s5) begin
      m5_r <= lo4_r - interp4_r;
      ip5_r <= ip4_r;
    end
    if (ld.s6) begin
      p6_r <= p6_nxt;
      ip6_r <= ip5_r;
    end
  end

  always_comb begin
    if (ip6_r > eif_pkg::IP_W'(eif_pkg::MAX_SHIFT)) begin
      term_o = '0;
    end else begin
      term_o = scaled >> ip6_r;
    end
  end

endmodule

>>> sv/exponential_integral_fit.sv
// An accepted word is registered in stage 1, passes lane stages 2 to 6 and leaves from stage 7 with out_tvalid.
// Throughput: one word per cycle; all seven register stages advance together while out_tready is high.
// A stalled output backs up stage by stage; empty stages still fill while it waits.
// Reset: synchronous, active low, clears the stage valid bits only.
// Depends on eif_pkg and eif_exp_lane.
module exponential_integral_fit #(
  parameter int EXP_TABLE_BITS = eif_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,   // [23:0] optical_depth
  input  logic [eif_pkg::ORD_W-1:0] in_tuser,   // [1:0] order
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [31:0]               out_tdata,  // [31:0] integral_value
  output logic                      out_tuser   // [0] order_error
);

  localparam int NST = 7;

  logic [NST:1]               v_r;
  logic [NST:1]               rdy;
  logic [eif_pkg::ORD_W-1:0]  ord_r [1:NST-1];
  logic [eif_pkg::X_W-1:0]    x1_r;
  logic                       in_acc;
  eif_pkg::eif_ld_t           ld;
  logic [eif_pkg::OUT_W-1:0]  term0;
  logic [eif_pkg::OUT_W-1:0]  term1;
  logic [eif_pkg::OUT_W:0]    sum;
  logic [31:0]                out_tdata_r;
  logic                       out_tuser_r;

  assign in_acc = in_tvalid && in_tready;
  assign in_tready = rdy[1];

  always_comb begin
    rdy[NST] = !v_r[NST] || out_tready;
    for (int s = NST - 1; s >= 1; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  assign ld.s2 = rdy[2] && v_r[1];
  assign ld.s3 = rdy[3] && v_r[2];
  assign ld.s4 = rdy[4] && v_r[3];
  assign ld.s5 = rdy[5] && v_r[4];
  assign ld.s6 = rdy[6] && v_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) begin
        v_r[1] <= in_tvalid;
      end
      for (int s = 2; s <= NST; s++) begin
        if (rdy[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ord_r[1] <= in_tuser;
      x1_r <= in_tdata[eif_pkg::X_W-1:0];
    end
    for (int s = 2; s <= NST - 1; s++) begin
      if (rdy[s] && v_r[s-1]) begin
        ord_r[s] <= ord_r[s-1];
      end
    end
    if (rdy[NST] && v_r[NST-1]) begin
      out_tuser_r <= (ord_r[NST-1] == eif_pkg::ORD_NONE);
      out_tdata_r <= (ord_r[NST-1] == eif_pkg::ORD_NONE) ? '0 : sum[31:0];
    end
  end

  eif_exp_lane #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_lane0 (
    .clk    (clk),
    .ld     (ld),
    .x_i    (x1_r),
    .k_i    (eif_pkg::coef_k(ord_r[1], 1'b0)),
    .a_i    (eif_pkg::coef_a(ord_r[5], 1'b0)),
    .term_o (term0)
  );

  eif_exp_lane #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_lane1 (
    .clk    (clk),
    .ld     (ld),
    .x_i    (x1_r),
    .k_i    (eif_pkg::coef_k(ord_r[1], 1'b1)),
    .a_i    (eif_pkg::coef_a(ord_r[5], 1'b1)),
    .term_o (term1)
  );

  assign sum = (eif_pkg::OUT_W + 1)'(term0) + (eif_pkg::OUT_W + 1)'(term1);

  assign out_tvalid = v_r[NST];
  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("order error word carries a nonzero value");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && !out_tready |-> !in_tready)
    else $error("input taken while every stage is full and output stalled");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[NST] |-> in_tready)
    else $error("input stalled while output stage is empty");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && !v_r[NST] |=> v_r[NST])
    else $error("word lost between last lane stage and output");
`endif

endmodule

>>> test/exponential_integral_fit_tb.sv
`timescale 1ns / 100ps
// Testbench for exponential_integral_fit: streams order/depth words and checks each result
// against an in-bench fixed-point model of the two-term exponential fit. Needs eif_pkg.
module exponential_integral_fit_tb;

  localparam int TBL_BITS = eif_pkg::EXP_TABLE_BITS_DEF;
  localparam int TBL_SIZE = 1 << TBL_BITS;
  localparam int SUB_BITS = 32 - TBL_BITS;
  localparam logic [63:0] LOG2_E_FIX = 64'h1_7154_7652;

  typedef logic [eif_pkg::ORD_W-1:0] order_t;

  typedef struct {
    logic [31:0] value;
    logic        err;
  } fit_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [23:0]  in_tdata = '0;   // [23:0] optical_depth
  order_t       in_tuser = eif_pkg::ORD_NONE;   // [1:0] order
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;   // [31:0] integral_value
  logic         out_tuser;   // [0] order_error

  logic [63:0]  root_fac [0:TBL_BITS-1];
  logic [63:0]  pow2_table [0:TBL_SIZE];
  fit_result_t  pending_fits [$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int cycle_cnt = 0;
  int hold_until = 0;
  int mismatch_cnt = 0;
  int checked_cnt = 0;
  int flagged_cnt = 0;
  int underflow_cnt = 0;
  int input_stall_cycles = 0;

  exponential_integral_fit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] b;
    rem = v;
    root = '0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  initial begin : build_pow2_table
    logic [63:0] v;
    logic [63:0] p;
    for (int k = 0; k < TBL_BITS; k++) begin
      v = 64'd1 << 30;
      for (int n = 0; n < TBL_BITS - k; n++) v = int_sqrt(v << 31);
      root_fac[k] = v;
    end
    for (int j = 0; j < TBL_SIZE; j++) begin
      p = 64'd1 << 31;
      for (int k = 0; k < TBL_BITS; k++) begin
        if (((j >> k) & 1) != 0) p = (p * root_fac[k] + (64'd1 << 30)) >> 31;
      end
      pow2_table[j] = p;
    end
    pow2_table[TBL_SIZE] = 64'd1 << 30;
  end

  // Fit constants in units of 1e-4; term 0 is the fast decay, term 1 the slow one.
  function automatic void fit_coef(input order_t ord, input logic term,
                                   output logic [63:0] a_dec, output logic [63:0] b_dec);
    case (ord)
      eif_pkg::ORD_E2: begin
        a_dec = term ? 64'd7347 : 64'd2653;
        b_dec = term ? 64'd16240 : 64'd86590;
      end
      eif_pkg::ORD_E3: begin
        a_dec = term ? 64'd4071 : 64'd929;
        b_dec = term ? 64'd13300 : 64'd40800;
      end
      default: begin
        a_dec = term ? 64'd17080 : 64'd25910;
        b_dec = term ? 64'd21100 : 64'd187000;
      end
    endcase
  endfunction

  function automatic logic [63:0] decay_rate(input logic [63:0] b_dec);
    return (b_dec * LOG2_E_FIX + 64'd1280000) / 64'd2560000;
  endfunction

  function automatic logic [63:0] decay_term(input order_t ord, input logic term,
                                             input logic [23:0] x);
    logic [63:0] a_dec, b_dec, t, ip, f, j, r, lo, hi, m, aq;
    fit_coef(ord, term, a_dec, b_dec);
    t = {40'd0, x} * decay_rate(b_dec);
    ip = t >> 40;
    f = (t >> 8) & 64'hFFFF_FFFF;
    j = f >> SUB_BITS;
    r = f & ((64'd1 << SUB_BITS) - 1);
    lo = pow2_table[j];
    hi = pow2_table[j + 1];
    m = lo - (((lo - hi) * r) >> SUB_BITS);
    aq = ((a_dec << 29) + 64'd5000) / 64'd10000;
    if (ip > 32) return '0;
    return (aq * m) >> (31 + ip);
  endfunction

  function automatic fit_result_t predict_fit(input order_t ord, input logic [23:0] x);
    fit_result_t res;
    logic [63:0] sum;
    res.value = '0;
    res.err = 1'b0;
    if (ord == eif_pkg::ORD_NONE) begin
      res.err = 1'b1;
    end else begin
      sum = decay_term(ord, 1'b0, x) + decay_term(ord, 1'b1, x);
      res.value = sum[31:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic send_word(input order_t ord, input logic [23:0] x);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= x;
    in_tuser <= ord;
    @(posedge clk);
    while (!in_tready) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    pending_fits.push_back(predict_fit(ord, x));
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_depth;
    case ($urandom_range(3, 0))
      0:       return 24'($urandom_range(16'hFFFF, 0));
      1, 2:    return 24'($urandom_range(24'h3FFFF, 0));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic order_t rand_order;
    if ($urandom_range(9, 0) == 0) return eif_pkg::ORD_NONE;
    return order_t'($urandom_range(3, 1));
  endfunction

  task automatic send_random_words(input int n);
    for (int i = 0; i < n; i++) send_word(rand_order(), rand_depth());
  endtask

  // Zero, one LSB, full scale, x = 1.0 and both sides of the slow term's underflow point.
  task automatic test_directed;
    order_t      ords [3];
    logic [63:0] a_dec, b_dec, k, edge_x;
    ords = '{eif_pkg::ORD_E1, eif_pkg::ORD_E2, eif_pkg::ORD_E3};
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_word(eif_pkg::ORD_NONE, 24'd0);
    send_word(eif_pkg::ORD_NONE, 24'hFF_FFFF);
    foreach (ords[i]) begin
      fit_coef(ords[i], 1'b1, a_dec, b_dec);
      k = decay_rate(b_dec);
      edge_x = ((64'd33 << 40) + k - 1) / k;
      send_word(ords[i], 24'd0);
      send_word(ords[i], 24'd1);
      send_word(ords[i], 24'h01_0000);
      send_word(ords[i], 24'hFF_FFFF);
      send_word(ords[i], 24'(edge_x - 1));
      send_word(ords[i], 24'(edge_x));
    end
    drain();
  endtask

  task automatic test_streaming;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_random_words(340);
    drain();
  endtask

  task automatic test_sender_gaps;
    src_idle_pct = 72;
    sink_stall_pct = 0;
    send_random_words(340);
    drain();
  endtask

  task automatic test_receiver_stalls;
    src_idle_pct = 0;
    sink_stall_pct = 72;
    send_random_words(340);
    drain();
  endtask

  task automatic test_mixed_idling;
    src_idle_pct = 11;
    sink_stall_pct = 11;
    send_random_words(340);
    drain();
  endtask

  // Hold the output off long enough for the pipeline to fill and push back on the input.
  task automatic test_backpressure;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_until = cycle_cnt + 120;
    send_random_words(48);
    drain();
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt < hold_until) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    fit_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_fits.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h/%b", out_tdata, out_tuser));
      end else begin
        want = pending_fits.pop_front();
        checked_cnt++;
        if (want.err) flagged_cnt++;
        else if (want.value == 0) underflow_cnt++;
        if (out_tdata !== want.value) begin
          report_mismatch($sformatf("integral_value %h, want %h", out_tdata, want.value));
        end
        if (out_tuser !== want.err) begin
          report_mismatch($sformatf("order_error %b, want %b", out_tuser, want.err));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results pending", pending_fits.size());
    $display("FAIL exponential_integral_fit");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_backpressure();
    $display("Checked %0d results: %0d with unsupported order, %0d underflowed to zero.",
             checked_cnt, flagged_cnt, underflow_cnt);
    $display("Input held off for %0d cycles across idle, stall and hold-off phases.",
             input_stall_cycles);
    if (mismatch_cnt == 0 && pending_fits.size() == 0) begin
      $display("PASS exponential_integral_fit");
    end else begin
      $display("FAIL exponential_integral_fit");
    end
    $finish;
  end

endmodule

>>> files.f
sv/eif_pkg.sv
sv/eif_exp_lane.sv
sv/exponential_integral_fit.sv
test/exponential_integral_fit_tb.sv
